>>> src/dltq_pkg.sv
// Shared types, constants and codes for the delta-list timer queue.
package dltq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int ID_BITS_DEF   = 8;
    localparam int TIME_BITS_DEF = 16;

    localparam logic REQ_SET  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic EVT_EXPIRED  = 1'b0;
    localparam logic EVT_REJECTED = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  timer_id;
        logic [15:0] duration;
    } t_req;

    typedef struct packed {
        logic       event_kind;
        logic [7:0] event_id;
        logic       last_event;
    } t_evt;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REJECT,
        ST_WALK_RD,
        ST_WALK_EV,
        ST_SH_RD,
        ST_SH_WR,
        ST_INSERT,
        ST_TICK_RD,
        ST_TICK_EV,
        ST_TICK_LAST,
        ST_CMP_RD,
        ST_CMP_WR
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_REJECT,
        OP_WALK_STEP,
        OP_SH_START,
        OP_SH_RD,
        OP_SH_WR,
        OP_INSERT,
        OP_TICK_RD,
        OP_TICK_TAKE,
        OP_KEEP_HEAD,
        OP_CMP_START,
        OP_CMP_RD,
        OP_CMP_WR,
        OP_CMP_DONE
    } t_op;

    // Command from the controller; emit sends the held expired id out
    typedef struct packed {
        t_op  op;
        logic emit;
        logic emit_last;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic walk_more;
        logic walk_last;
        logic sh_at_pos;
        logic expires;
        logic tick_last;
        logic pos_zero;
        logic cmp_done;
    } t_sts;

endpackage

>>> src/delta_list_timer_queue_unit.sv
// Top level of the delta-list timer queue: controller plus datapath.
//
//  channel   direction  handshake                 word
//  request   in         start, busy               i_req  (req_type, timer_id, duration)
//  result    out        o_strobe (one cycle)      o_evt  (event_kind, event_id, last_event)
//
// A request is taken on a rising edge with start high and busy low; busy then stays high
// until it is done. A set walks past the entries ahead of it, moves the later entries up
// one place (none when it lands at the tail) and inserts; it is rejected on a full list.
// A tick hands out each expired entry and moves the survivors down, or else decrements
// the head when none expires; busy does not rise for a tick on an empty list.
// Synchronous active-low reset empties the list. Results cannot be stalled.
module delta_list_timer_queue_unit #(
    parameter int DEPTH     = dltq_pkg::DEPTH_DEF,
    parameter int ID_BITS   = dltq_pkg::ID_BITS_DEF,
    parameter int TIME_BITS = dltq_pkg::TIME_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  dltq_pkg::t_req i_req,
    output logic           o_strobe,
    output dltq_pkg::t_evt o_evt
);

    dltq_pkg::t_cmd cmd;
    dltq_pkg::t_sts sts;

    // Sequence the set walk, shift, tick scan and compaction
    dltq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req.req_type),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .busy       (busy)
    );

    // Hold the list and produce results
    dltq_dp #(
        .DEPTH     (DEPTH),
        .ID_BITS   (ID_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_strobe (o_strobe),
        .o_evt    (o_evt)
    );

endmodule

>>> src/dltq_ctrl.sv
// Controller state machine for the delta-list timer queue.
module dltq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  logic           i_req_type,
    input  dltq_pkg::t_sts i_sts,
    output dltq_pkg::t_cmd o_cmd,
    output logic           busy
);

    dltq_pkg::t_state r_state;
    dltq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dltq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd.op        = dltq_pkg::OP_NONE;
        o_cmd.emit      = 1'b0;
        o_cmd.emit_last = 1'b0;
        busy            = (r_state != dltq_pkg::ST_IDLE);
        unique case (r_state)
            dltq_pkg::ST_IDLE: begin
                if (start) begin
                    o_cmd.op = dltq_pkg::OP_LOAD;
                    if (i_req_type == dltq_pkg::REQ_TICK) begin
                        if (!i_sts.empty) begin
                            n_state = dltq_pkg::ST_TICK_RD;
                        end
                    end else if (i_sts.full) begin
                        n_state = dltq_pkg::ST_REJECT;
                    end else if (i_sts.empty) begin
                        n_state = dltq_pkg::ST_INSERT;
                    end else begin
                        n_state = dltq_pkg::ST_WALK_RD;
                    end
                end
            end
            dltq_pkg::ST_REJECT: begin
                o_cmd.op = dltq_pkg::OP_REJECT;
                n_state  = dltq_pkg::ST_IDLE;
            end
            dltq_pkg::ST_WALK_RD: begin
                n_state = dltq_pkg::ST_WALK_EV;
            end
            dltq_pkg::ST_WALK_EV: begin
                if (i_sts.walk_more) begin
                    o_cmd.op = dltq_pkg::OP_WALK_STEP;
                    n_state  = i_sts.walk_last ? dltq_pkg::ST_INSERT : dltq_pkg::ST_WALK_RD;
                end else begin
                    o_cmd.op = dltq_pkg::OP_SH_START;
                    n_state  = dltq_pkg::ST_SH_RD;
                end
            end
            dltq_pkg::ST_SH_RD: begin
                o_cmd.op = dltq_pkg::OP_SH_RD;
                n_state  = dltq_pkg::ST_SH_WR;
            end
            dltq_pkg::ST_SH_WR: begin
                o_cmd.op = dltq_pkg::OP_SH_WR;
                n_state  = i_sts.sh_at_pos ? dltq_pkg::ST_INSERT : dltq_pkg::ST_SH_RD;
            end
            dltq_pkg::ST_INSERT: begin
                o_cmd.op = dltq_pkg::OP_INSERT;
                n_state  = dltq_pkg::ST_IDLE;
            end
            dltq_pkg::ST_TICK_RD: begin
                o_cmd.op = dltq_pkg::OP_TICK_RD;
                n_state  = dltq_pkg::ST_TICK_EV;
            end
            dltq_pkg::ST_TICK_EV: begin
                if (i_sts.expires) begin
                    // hand out the previous expiry, hold this one
                    o_cmd.op   = dltq_pkg::OP_TICK_TAKE;
                    o_cmd.emit = !i_sts.pos_zero;
                    n_state    = i_sts.tick_last ? dltq_pkg::ST_TICK_LAST
                                                 : dltq_pkg::ST_TICK_RD;
                end else if (i_sts.pos_zero) begin
                    o_cmd.op = dltq_pkg::OP_KEEP_HEAD;
                    n_state  = dltq_pkg::ST_IDLE;
                end else begin
                    o_cmd.op        = dltq_pkg::OP_CMP_START;
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    n_state         = dltq_pkg::ST_CMP_RD;
                end
            end
            dltq_pkg::ST_TICK_LAST: begin
                o_cmd.op        = dltq_pkg::OP_CMP_START;
                o_cmd.emit      = 1'b1;
                o_cmd.emit_last = 1'b1;
                n_state         = dltq_pkg::ST_CMP_RD;
            end
            dltq_pkg::ST_CMP_RD: begin
                if (i_sts.cmp_done) begin
                    o_cmd.op = dltq_pkg::OP_CMP_DONE;
                    n_state  = dltq_pkg::ST_IDLE;
                end else begin
                    o_cmd.op = dltq_pkg::OP_CMP_RD;
                    n_state  = dltq_pkg::ST_CMP_WR;
                end
            end
            dltq_pkg::ST_CMP_WR: begin
                o_cmd.op = dltq_pkg::OP_CMP_WR;
                n_state  = dltq_pkg::ST_CMP_RD;
            end
            default: begin
                n_state = dltq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> src/dltq_dp.sv
// Datapath of the delta-list timer queue: list memory, walk and shift pointers, result register.
module dltq_dp #(
    parameter int DEPTH     = dltq_pkg::DEPTH_DEF,
    parameter int ID_BITS   = dltq_pkg::ID_BITS_DEF,
    parameter int TIME_BITS = dltq_pkg::TIME_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dltq_pkg::t_req i_req,
    input  dltq_pkg::t_cmd i_cmd,
    output dltq_pkg::t_sts o_sts,
    output logic           o_strobe,
    output dltq_pkg::t_evt o_evt
);

    localparam int IDW = (ID_BITS < 8) ? ID_BITS : 8;
    localparam int TW  = (TIME_BITS < 16) ? TIME_BITS : 16;
    localparam int EW  = IDW + TW;
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int IW  = $clog2(DEPTH);

    logic [EW-1:0]  r_mem [DEPTH];
    logic [EW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;
    logic [CW-1:0]  r_pos;
    logic [CW-1:0]  r_ptr;
    logic [TW-1:0]  r_rem;
    logic [IDW-1:0] r_id;
    logic [IDW-1:0] r_pend;
    logic           r_strobe;
    dltq_pkg::t_evt r_evt;

    logic [TW-1:0]  rd_delta;
    logic [IDW-1:0] rd_id;
    logic [CW-1:0]  cmp_src;
    logic [CW-1:0]  rd_addr;
    logic           wr_en;
    logic [CW-1:0]  wr_addr;
    logic [EW-1:0]  wr_data;

    assign rd_delta = r_rd[TW-1:0];
    assign rd_id    = r_rd[EW-1:TW];
    assign cmp_src  = r_ptr + r_pos;

    assign o_sts.full      = (r_cnt == CW'(DEPTH));
    assign o_sts.empty     = (r_cnt == '0);
    assign o_sts.walk_more = (r_rem > rd_delta);
    assign o_sts.walk_last = ((r_pos + CW'(1)) == r_cnt);
    assign o_sts.sh_at_pos = (r_ptr == r_pos);
    assign o_sts.pos_zero  = (r_pos == '0);
    assign o_sts.expires   = (r_pos == '0) ? (rd_delta <= TW'(1)) : (rd_delta == '0);
    assign o_sts.tick_last = ((r_pos + CW'(1)) == r_cnt);
    assign o_sts.cmp_done  = (cmp_src == r_cnt);

    // Read address and write port follow the command
    always_comb begin
        rd_addr = r_pos;
        wr_en   = 1'b0;
        wr_addr = r_pos;
        wr_data = {r_id, r_rem};
        unique case (i_cmd.op)
            dltq_pkg::OP_SH_RD:  rd_addr = r_ptr;
            dltq_pkg::OP_CMP_RD: rd_addr = cmp_src;
            dltq_pkg::OP_SH_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_ptr + CW'(1);
                wr_data = {rd_id, (r_ptr == r_pos) ? (rd_delta - r_rem) : rd_delta};
            end
            dltq_pkg::OP_INSERT: begin
                wr_en = 1'b1;
            end
            dltq_pkg::OP_KEEP_HEAD: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = {rd_id, rd_delta - TW'(1)};
            end
            dltq_pkg::OP_CMP_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_ptr;
                wr_data = r_rd;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr[IW-1:0]] <= wr_data;
        end
        r_rd <= r_mem[rd_addr[IW-1:0]];
    end

    // Control state: fill count and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit || (i_cmd.op == dltq_pkg::OP_REJECT);
            if (i_cmd.op == dltq_pkg::OP_INSERT) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_cmd.op == dltq_pkg::OP_CMP_DONE) begin
                r_cnt <= r_cnt - r_pos;
            end
        end
    end

    // Walk pointers, remainder and held ids
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            dltq_pkg::OP_LOAD: begin
                r_id  <= i_req.timer_id[IDW-1:0];
                r_rem <= i_req.duration[TW-1:0];
                r_pos <= '0;
                r_ptr <= '0;
            end
            dltq_pkg::OP_WALK_STEP: begin
                r_rem <= r_rem - rd_delta;
                r_pos <= r_pos + CW'(1);
            end
            dltq_pkg::OP_SH_START: r_ptr <= r_cnt - CW'(1);
            dltq_pkg::OP_SH_WR:    r_ptr <= r_ptr - CW'(1);
            dltq_pkg::OP_TICK_TAKE: begin
                r_pend <= rd_id;
                r_pos  <= r_pos + CW'(1);
            end
            dltq_pkg::OP_CMP_START: r_ptr <= '0;
            dltq_pkg::OP_CMP_WR:    r_ptr <= r_ptr + CW'(1);
            default: begin
            end
        endcase
        if (i_cmd.op == dltq_pkg::OP_REJECT) begin
            r_evt.event_kind <= dltq_pkg::EVT_REJECTED;
            r_evt.event_id   <= 8'(r_id);
            r_evt.last_event <= 1'b1;
        end else begin
            r_evt.event_kind <= dltq_pkg::EVT_EXPIRED;
            r_evt.event_id   <= 8'(r_pend);
            r_evt.last_event <= i_cmd.emit_last;
        end
    end

    assign o_strobe = r_strobe;
    assign o_evt    = r_evt;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_no_insert_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == dltq_pkg::OP_INSERT) |-> (r_cnt < CW'(DEPTH)))
        else $error("insert into a full list");

    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == dltq_pkg::OP_SH_WR) |-> (r_ptr < r_cnt && r_ptr >= r_pos))
        else $error("shift pointer outside live entries");

    a_reject_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == dltq_pkg::OP_REJECT) |=> (o_strobe && o_evt.last_event))
        else $error("rejection not marked as last word");

endmodule

>>> tb/dltq_event_checker.sv
`timescale 1ns / 1ps
// Event checker for the delta-list timer queue: predicts and compares result words.
module dltq_event_checker #(
    parameter int DEPTH = dltq_pkg::DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_busy,
    input  dltq_pkg::t_req i_req,
    input  logic           i_strobe,
    input  dltq_pkg::t_evt i_evt,
    output int             o_pending,
    output int             o_fail_count
);

    // Shadow copy of the timer list
    logic [7:0]         timer_slot_id    [DEPTH];
    logic signed [16:0] timer_slot_delta [DEPTH];
    int                 live_timers;

    dltq_pkg::t_evt expected_events [$];
    int             fail_total = 0;

    assign o_fail_count = fail_total;

    task automatic report_fault(input string what, input dltq_pkg::t_evt want,
                                input dltq_pkg::t_evt got);
        if (fail_total < 10)
            $display("%0t ns: %s: expected kind %0d id %0d last %0d, got kind %0d id %0d last %0d",
                     $time, what, want.event_kind, want.event_id, want.last_event,
                     got.event_kind, got.event_id, got.last_event);
        fail_total++;
    endtask

    // Apply one accepted request to the shadow list and queue the events it raises
    task automatic apply_request(input dltq_pkg::t_req w);
        int                 pos;
        int                 expired;
        int                 k;
        logic signed [17:0] remainder;
        dltq_pkg::t_evt     e;
        if (w.req_type == dltq_pkg::REQ_SET) begin
            if (live_timers >= DEPTH) begin
                e.event_kind = dltq_pkg::EVT_REJECTED;
                e.event_id   = w.timer_id;
                e.last_event = 1'b1;
                expected_events.push_back(e);
            end else begin
                pos       = 0;
                remainder = {2'b00, w.duration};
                while (pos < live_timers && remainder > timer_slot_delta[pos]) begin
                    remainder = remainder - timer_slot_delta[pos];
                    pos++;
                end
                if (pos < live_timers)
                    timer_slot_delta[pos] = timer_slot_delta[pos] - remainder[16:0];
                for (k = live_timers; k > pos; k--) begin
                    timer_slot_id[k]    = timer_slot_id[k-1];
                    timer_slot_delta[k] = timer_slot_delta[k-1];
                end
                timer_slot_id[pos]    = w.timer_id;
                timer_slot_delta[pos] = remainder[16:0];
                live_timers++;
            end
        end else if (live_timers > 0) begin
            timer_slot_delta[0] = timer_slot_delta[0] - 17'sd1;
            expired = 0;
            while (expired < live_timers && timer_slot_delta[expired] <= 0)
                expired++;
            for (k = 0; k < expired; k++) begin
                e.event_kind = dltq_pkg::EVT_EXPIRED;
                e.event_id   = timer_slot_id[k];
                e.last_event = (k == expired - 1);
                expected_events.push_back(e);
            end
            for (k = 0; k < live_timers - expired; k++) begin
                timer_slot_id[k]    = timer_slot_id[k+expired];
                timer_slot_delta[k] = timer_slot_delta[k+expired];
            end
            live_timers -= expired;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            live_timers = 0;
            expected_events.delete();
        end else begin
            if (i_strobe) begin
                if (expected_events.size() == 0)
                    report_fault("unexpected result word", '0, i_evt);
                else begin
                    dltq_pkg::t_evt want;
                    want = expected_events.pop_front();
                    if (i_evt.event_kind !== want.event_kind ||
                        i_evt.event_id !== want.event_id ||
                        i_evt.last_event !== want.last_event)
                        report_fault("result mismatch", want, i_evt);
                end
            end
            if (i_start && !i_busy)
                apply_request(i_req);
        end
        o_pending <= expected_events.size();
    end

endmodule

>>> tb/tb_delta_list_timer_queue_unit.sv
`timescale 1ns / 1ps
// Testbench top for the delta-list timer queue: stimulus, timeout and verdict.
module tb_delta_list_timer_queue_unit;

    // Settle time scales with the list depth; allow margin
    localparam int SETTLE_CYCLES = 4 * dltq_pkg::DEPTH_DEF + 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_WORDS   = 160;

    logic           i_clk     = 1'b0;
    logic           i_rst_n   = 1'b0;
    logic           start     = 1'b0;
    logic           busy;
    dltq_pkg::t_req req_word  = '0;
    logic           evt_strobe;
    dltq_pkg::t_evt evt_word;

    int pending_events;
    int fail_count;
    int cycle_count = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    delta_list_timer_queue_unit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (req_word),
        .o_strobe (evt_strobe),
        .o_evt    (evt_word)
    );

    dltq_event_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (req_word),
        .i_strobe     (evt_strobe),
        .i_evt        (evt_word),
        .o_pending    (pending_events),
        .o_fail_count (fail_count)
    );

    // Present a request word and hold it until the queue takes it. Start is left
    // high afterwards so back-to-back words need no extra edge.
    task automatic send_word(input dltq_pkg::t_req w);
        start    <= 1'b1;
        req_word <= w;
        do @(posedge i_clk); while (busy);
    endtask

    // Drop start for one cycle
    task automatic idle_cycle();
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic dltq_pkg::t_req set_word(input logic [7:0] id,
                                                input logic [15:0] ticks);
        dltq_pkg::t_req w;
        w.req_type = dltq_pkg::REQ_SET;
        w.timer_id = id;
        w.duration = ticks;
        return w;
    endfunction

    // Id and duration are ignored on a tick; fill them with noise anyway
    function automatic dltq_pkg::t_req tick_word();
        dltq_pkg::t_req w;
        w.req_type = dltq_pkg::REQ_TICK;
        w.timer_id = 8'($urandom_range(0, 255));
        w.duration = 16'($urandom_range(0, 65535));
        return w;
    endfunction

    // Mostly short timers so that expiries keep coming; now and then a long one
    // to exercise the upper duration bits without clogging the list for good.
    function automatic dltq_pkg::t_req random_word();
        logic [15:0] ticks;
        if ($urandom_range(0, 99) < 45)
            return tick_word();
        if ($urandom_range(0, 59) == 0)
            ticks = 16'($urandom_range(0, 65535));
        else
            ticks = 16'($urandom_range(0, 20));
        return set_word(8'($urandom_range(0, 255)), ticks);
    endfunction

    // Send a run of random words, idling start with the given percentage per cycle
    task automatic run_phase(input int words, input int idle_pct);
        for (int n = 0; n < words; n++) begin
            while ($urandom_range(0, 99) < idle_pct)
                idle_cycle();
            send_word(random_word());
        end
    endtask

    // Watchdog: count cycles and give up at the limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        // Hold reset, release on a rising edge
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Tick on an empty list: no word back
        send_word(tick_word());
        // Zero durations go in at the head; the second lands ahead of the first
        send_word(set_word(8'hFF, 16'd0));
        send_word(set_word(8'h00, 16'd0));
        // One tick expires both, the second marked last
        send_word(tick_word());
        // Equal durations: the newer timer takes the head and the old head drops to zero
        send_word(set_word(8'h11, 16'd5));
        send_word(set_word(8'h22, 16'd5));
        send_word(set_word(8'h33, 16'd3));
        send_word(set_word(8'h44, 16'hFFFF));
        send_word(set_word(8'h55, 16'd7));
        // Two ticks with no expiry, the third expires the shortest
        repeat (3) send_word(tick_word());
        // Fill the list to the brim, then one more set is rejected
        for (int k = 0; k < 12; k++)
            send_word(set_word(8'(8'hA0 + k), 16'd2));
        send_word(set_word(8'hEE, 16'd1));

        // Light sender gaps first
        run_phase(PHASE_WORDS, 14);

        // Pause until every expected word has come back
        start <= 1'b0;
        do @(posedge i_clk); while (pending_events != 0);

        // Heavy sender gaps, then back-to-back words
        run_phase(PHASE_WORDS, 78);
        run_phase(PHASE_WORDS, 0);

        // Drain: wait for the last word back and the queue to go quiet
        start <= 1'b0;
        do @(posedge i_clk); while (pending_events != 0 || busy);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
